// File: sv/tps_pkg.sv
`default_nettype none
package tps_pkg;

  localparam int CW = 32;              // coordinate width
  localparam int FRAC_BITS = 16;       // fraction bits of the coordinate format
  localparam int LW = CW + 1;          // edge vector / offset width
  localparam int PW = CW + LW;         // one normal * vector product
  localparam int DW = PW + 2;          // dot product (three terms)
  localparam int QB = CW + 3;          // quotient bits kept before clamping
  localparam int NLO = (DW + 1) / 2;   // low slice of |numer| per multiply pass
  localparam int NHI = DW - NLO;       // high slice
  localparam int MW = DW + LW;         // |numer| * |l|
  localparam int CIW = 3;              // config index width

  localparam logic [CW-1:0] ONE_FX = CW'(1) << FRAC_BITS;

  localparam logic [CIW-1:0] REG_NORMAL_X = 3'd0;
  localparam logic [CIW-1:0] REG_NORMAL_Y = 3'd1;
  localparam logic [CIW-1:0] REG_NORMAL_Z = 3'd2;
  localparam logic [CIW-1:0] REG_ORIGIN_X = 3'd3;
  localparam logic [CIW-1:0] REG_ORIGIN_Y = 3'd4;
  localparam logic [CIW-1:0] REG_ORIGIN_Z = 3'd5;

  typedef logic [2:0][2:0][CW-1:0] tri_t;   // [vertex][axis]

  typedef struct packed {
    logic [2:0][CW-1:0] normal;
    logic [2:0][CW-1:0] origin;
  } plane_t;

  // one classified triangle between front and back
  typedef struct packed {
    tri_t               vert;
    logic [2:0][DW-1:0] denom;
    logic [2:0][DW-1:0] numer;
    logic [2:0]         inpl;
    logic [2:0]         zden;
    logic [2:0]         miss;
  } job_t;

endpackage
`default_nettype wire

// File: sv/tps_queue.sv
`default_nettype none
module tps_queue import tps_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t wdata,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head
);

  logic [1:0] count;
  logic       wptr;
  logic       rptr;
  job_t       slot [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wptr  <= 1'b0;
      rptr  <= 1'b0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wptr] <= wdata;
  end

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slot[rptr];

endmodule
`default_nettype wire

// File: sv/tps_front.sv
`default_nettype none
module tps_front import tps_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_stall,
  input  wire tri_t   vert_in,
  input  wire plane_t plane,
  input  wire logic   full,
  output logic        push,
  output job_t        wdata
);

  logic v1, v2, en1, en2;
  tri_t vt1, vt2;
  logic signed [PW-1:0] pd [3][3];
  logic signed [PW-1:0] pn [3][3];
  logic signed [PW-1:0] dn [3][3];
  logic signed [PW-1:0] nu [3][3];
  logic [2:0][DW-1:0] den2, num2;

  assign en2      = !v2 || !full;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;
  assign push     = v2 && !full;

  // products of the normal with edge vector and with vertex offset
  always_comb begin
    logic signed [LW-1:0] ld, ad;
    for (int e = 0; e < 3; e++) begin
      for (int i = 0; i < 3; i++) begin
        ld = $signed({vert_in[(e == 2) ? 0 : e + 1][i][CW-1],
                      vert_in[(e == 2) ? 0 : e + 1][i]})
           - $signed({vert_in[e][i][CW-1], vert_in[e][i]});
        ad = $signed({vert_in[e][i][CW-1], vert_in[e][i]})
           - $signed({plane.origin[i][CW-1], plane.origin[i]});
        pd[e][i] = $signed(plane.normal[i]) * ld;
        pn[e][i] = $signed(plane.normal[i]) * ad;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      vt1 <= vert_in;
      dn  <= pd;
      nu  <= pn;
    end
    if (en2 && v1) begin
      vt2 <= vt1;
      for (int e = 0; e < 3; e++) begin
        den2[e] <= {{2{dn[e][0][PW-1]}}, dn[e][0]} + {{2{dn[e][1][PW-1]}}, dn[e][1]}
                 + {{2{dn[e][2][PW-1]}}, dn[e][2]};
        num2[e] <= {{2{nu[e][0][PW-1]}}, nu[e][0]} + {{2{nu[e][1][PW-1]}}, nu[e][1]}
                 + {{2{nu[e][2][PW-1]}}, nu[e][2]};
      end
    end
  end

  // classification that needs no quotient
  always_comb begin
    logic signed [DW:0] negn, dext;
    logic zd, zn, behind, beyond;
    wdata.vert  = vt2;
    wdata.denom = den2;
    wdata.numer = num2;
    for (int e = 0; e < 3; e++) begin
      zd     = (den2[e] == '0);
      zn     = (num2[e] == '0);
      negn   = -$signed({num2[e][DW-1], num2[e]});
      dext   = $signed({den2[e][DW-1], den2[e]});
      behind = !zn && (num2[e][DW-1] == den2[e][DW-1]);
      beyond = den2[e][DW-1] ? (negn < dext) : (dext < negn);
      wdata.zden[e] = zd;
      wdata.inpl[e] = zd && zn;
      wdata.miss[e] = zd || behind || beyond;
    end
  end

endmodule
`default_nettype wire

// File: sv/tps_div.sv
`default_nettype none
module tps_div import tps_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] nmag,
  input  wire logic [LW-1:0] lmag,
  input  wire logic [DW-1:0] dmag,
  output logic               done,
  output logic [QB-1:0]      qmag
);

  typedef enum logic [5:0] {
    D_IDLE = 6'b000001,
    D_MLO  = 6'b000010,
    D_MHI  = 6'b000100,
    D_SUM  = 6'b001000,
    D_PREP = 6'b010000,
    D_DIV  = 6'b100000
  } dstate_t;

  dstate_t                 state;
  logic [DW-1:0]           na, dv;
  logic [LW-1:0]           la;
  logic [NLO+LW-1:0]       pplo;
  logic [NHI+LW-1:0]       pphi;
  logic [MW-1:0]           m;
  logic [QB-1:0]           lowbits, q;
  logic [DW-1:0]           rem;
  logic                    ovf;
  logic [$clog2(QB)-1:0]   cnt;
  logic [DW:0]             trial;

  assign trial = {rem, lowbits[QB-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: if (start) state <= D_MLO;
        D_MLO:  state <= D_MHI;
        D_MHI:  state <= D_SUM;
        D_SUM:  state <= D_PREP;
        D_PREP: state <= D_DIV;
        D_DIV: begin
          if (cnt == '0) begin
            state <= D_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      D_IDLE: begin
        na <= nmag;
        la <= lmag;
        dv <= dmag;
      end
      D_MLO: pplo <= na[NLO-1:0] * la;
      D_MHI: pphi <= na[DW-1:NLO] * la;
      D_SUM: m <= {pphi, {NLO{1'b0}}} + MW'(pplo);
      D_PREP: begin
        ovf     <= {{(DW+QB-MW){1'b0}}, m[MW-1:QB]} >= dv;
        rem     <= {{(DW+QB-MW){1'b0}}, m[MW-1:QB]};
        lowbits <= m[QB-1:0];
        q       <= '0;
        cnt     <= ($clog2(QB))'(QB - 1);
      end
      D_DIV: begin
        if (trial >= {1'b0, dv}) begin
          rem <= DW'(trial - {1'b0, dv});
          q   <= {q[QB-2:0], 1'b1};
        end else begin
          rem <= trial[DW-1:0];
          q   <= {q[QB-2:0], 1'b0};
        end
        lowbits <= {lowbits[QB-2:0], 1'b0};
        cnt     <= cnt - 1'b1;
      end
      default: ;
    endcase
  end

  // a quotient past QB bits saturates the coordinate anyway
  assign qmag = ovf ? {QB{1'b1}} : q;

endmodule
`default_nettype wire

// File: sv/tps_back.sv
`default_nettype none
module tps_back import tps_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    head_valid,
  input  wire job_t    head,
  output logic         pop,
  output logic         out_valid,
  input  wire logic    out_stall,
  output logic [CW-1:0] point_x,
  output logic [CW-1:0] point_y,
  output logic [CW-1:0] point_z,
  output logic         last
);

  typedef enum logic [5:0] {
    B_IDLE  = 6'b000001,
    B_START = 6'b000010,
    B_WAIT  = 6'b000100,
    B_FIN   = 6'b001000,
    B_CLASS = 6'b010000,
    B_EMIT  = 6'b100000
  } bstate_t;

  typedef enum logic [1:0] {SEL_Q0, SEL_Q1, SEL_Q2, SEL_MID} sel_t;
  typedef enum logic [1:0] {EC_MISS, EC_CROSS, EC_TOUCH} eclass_t;

  bstate_t            state;
  logic [1:0]         e, enext;
  logic [2:0][2:0][CW-1:0] qv;
  logic [2:0][CW-1:0] mid_r, mid_c, fin_q;
  sel_t               lst_r [6];
  sel_t               lst_c [6];
  logic [2:0]         n_r, n_c, k;
  logic [2:0]         done;
  logic [2:0][QB-1:0] qmag;
  logic [2:0][LW-1:0] lmag;
  logic [2:0]         lneg;
  logic [DW-1:0]      nmag, dmag;
  logic               unit_start, slot_free;
  logic [2:0][CW-1:0] emit_pt;

  function automatic sel_t sel_of(input logic [1:0] idx);
    case (idx)
      2'd0:    return SEL_Q0;
      2'd1:    return SEL_Q1;
      default: return SEL_Q2;
    endcase
  endfunction

  assign enext = (e == 2'd2) ? 2'd0 : e + 2'd1;

  // operand magnitudes for the current edge
  always_comb begin
    logic signed [LW-1:0] l;
    for (int i = 0; i < 3; i++) begin
      l = $signed({head.vert[enext][i][CW-1], head.vert[enext][i]})
        - $signed({head.vert[e][i][CW-1], head.vert[e][i]});
      lneg[i] = l[LW-1];
      lmag[i] = l[LW-1] ? LW'(-l) : LW'(l);
    end
    nmag = head.numer[e][DW-1] ? -head.numer[e] : head.numer[e];
    dmag = head.denom[e][DW-1] ? -head.denom[e] : head.denom[e];
  end

  assign unit_start = (state == B_START) && !head.zden[e];

  for (genvar g = 0; g < 3; g++) begin : g_axis
    tps_div u_div (
      .clk   (clk),
      .rst   (rst),
      .start (unit_start),
      .nmag  (nmag),
      .lmag  (lmag[g]),
      .dmag  (dmag),
      .done  (done[g]),
      .qmag  (qmag[g])
    );
  end

  // point = a + signed quotient, saturated
  always_comb begin
    logic               qneg;
    logic signed [QB+1:0] qs, s;
    for (int i = 0; i < 3; i++) begin
      qneg = !(head.numer[e][DW-1] ^ lneg[i] ^ head.denom[e][DW-1]);
      qs   = qneg ? -$signed({2'b00, qmag[i]}) : $signed({2'b00, qmag[i]});
      s    = $signed({{(QB+2-CW){head.vert[e][i][CW-1]}}, head.vert[e][i]}) + qs;
      if (&s[QB+1:CW-1] || !(|s[QB+1:CW-1]))
        fin_q[i] = s[CW-1:0];
      else
        fin_q[i] = s[QB+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
  end

  // per-triangle case table
  always_comb begin
    eclass_t    f [3];
    eclass_t    fa [3];
    logic [2:0] mask;
    logic       use_mask;
    logic [1:0] ninp;
    logic [2:0] sum;
    logic [1:0] ma, mb;
    logic signed [CW:0] ms;
    for (int j = 0; j < 6; j++) lst_c[j] = SEL_Q0;
    n_c      = 3'd0;
    mask     = 3'b000;
    use_mask = 1'b0;
    ma       = 2'd1;
    mb       = 2'd2;
    for (int x = 0; x < 3; x++) begin
      if (head.miss[x])
        f[x] = EC_MISS;
      else if (qv[x] == head.vert[x] || qv[x] == head.vert[(x == 2) ? 0 : x + 1])
        f[x] = EC_TOUCH;
      else
        f[x] = EC_CROSS;
      fa[x] = f[x];
    end
    ninp = 2'(head.inpl[0]) + 2'(head.inpl[1]) + 2'(head.inpl[2]);
    sum  = 3'(f[0]) + 3'(f[1]) + 3'(f[2]);
    if (ninp == 2'd1) begin
      use_mask = 1'b1;
      mask     = ~head.inpl;
    end else if (ninp == 2'd0) begin
      case (sum)
        3'd6: begin
          lst_c[0] = SEL_Q0; lst_c[1] = SEL_Q1; lst_c[2] = SEL_Q1;
          lst_c[3] = SEL_Q2; lst_c[4] = SEL_Q2; lst_c[5] = SEL_Q0;
          n_c = 3'd6;
        end
        3'd5: begin
          if (fa[0] == EC_TOUCH) fa[0] = EC_MISS;
          else if (fa[1] == EC_TOUCH) fa[1] = EC_MISS;
          use_mask = 1'b1;
          for (int x = 0; x < 3; x++) mask[x] = (fa[x] != EC_MISS);
        end
        3'd3: begin
          use_mask = 1'b1;
          for (int x = 0; x < 3; x++) mask[x] = (f[x] != EC_MISS);
        end
        3'd4: begin
          use_mask = 1'b1;
          if (f[0] == EC_MISS) mask = 3'b110;
          else if (f[1] == EC_MISS) mask = 3'b101;
          else if (f[2] == EC_MISS) mask = 3'b011;
        end
        3'd2: begin
          use_mask = 1'b1;
          for (int x = 0; x < 3; x++) mask[x] = (f[x] == EC_CROSS);
        end
        3'd1: begin
          // crossing point, then midpoint of the two other edge points
          if (f[0] == EC_CROSS) begin
            lst_c[0] = SEL_Q0; ma = 2'd1; mb = 2'd2;
          end else if (f[1] == EC_CROSS) begin
            lst_c[0] = SEL_Q1; ma = 2'd0; mb = 2'd2;
          end else begin
            lst_c[0] = SEL_Q2; ma = 2'd0; mb = 2'd1;
          end
          lst_c[1] = SEL_MID;
          n_c = 3'd2;
        end
        default: ;
      endcase
    end
    if (use_mask) begin
      for (int x = 0; x < 3; x++) begin
        if (mask[x]) begin
          lst_c[n_c] = sel_of(2'(x));
          n_c = n_c + 3'd1;
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      ms = $signed({qv[ma][i][CW-1], qv[ma][i]}) + $signed({qv[mb][i][CW-1], qv[mb][i]});
      ms = ms + $signed({{CW{1'b0}}, ms[CW]});
      mid_c[i] = ms[CW:1];
    end
  end

  assign pop       = (state == B_CLASS);
  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      e     <= 2'd0;
      k     <= 3'd0;
    end else begin
      case (state)
        B_IDLE: begin
          e <= 2'd0;
          if (head_valid) state <= B_START;
        end
        B_START: begin
          if (head.zden[e]) begin
            if (e == 2'd2) state <= B_CLASS;
            else e <= e + 2'd1;
          end else begin
            state <= B_WAIT;
          end
        end
        B_WAIT: if (done[0]) state <= B_FIN;
        B_FIN: begin
          if (e == 2'd2) begin
            state <= B_CLASS;
          end else begin
            e     <= e + 2'd1;
            state <= B_START;
          end
        end
        B_CLASS: begin
          k     <= 3'd0;
          state <= (n_c == 3'd0) ? B_IDLE : B_EMIT;
        end
        B_EMIT: begin
          if (slot_free) begin
            if (k == n_r - 3'd1) state <= B_IDLE;
            else k <= k + 3'd1;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_START && head.zden[e]) qv[e] <= '0;
    if (state == B_FIN) qv[e] <= fin_q;
    if (state == B_CLASS) begin
      lst_r <= lst_c;
      n_r   <= n_c;
      mid_r <= mid_c;
    end
  end

  always_comb begin
    case (lst_r[k])
      SEL_Q0:  emit_pt = qv[0];
      SEL_Q1:  emit_pt = qv[1];
      SEL_Q2:  emit_pt = qv[2];
      SEL_MID: emit_pt = mid_r;
      default: emit_pt = mid_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= (state == B_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && state == B_EMIT) begin
      point_x <= emit_pt[0];
      point_y <= emit_pt[1];
      point_z <= emit_pt[2];
      last    <= (k == n_r - 3'd1);
    end
  end

  a_units_together: assert property (@(posedge clk) disable iff (rst)
    done[0] |-> (done[1] && done[2]))
    else $error("axis dividers out of step");

  a_pop_has_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_emit_in_list: assert property (@(posedge clk) disable iff (rst)
    (state == B_EMIT) |-> (k < n_r))
    else $error("emit index past point list");

  a_wait_started: assert property (@(posedge clk) disable iff (rst)
    (state == B_WAIT) && $past(state == B_START) |-> !head.zden[e])
    else $error("divide on parallel edge");

endmodule
`default_nettype wire

// File: sv/triangle_plane_slicer.sv
// Flow: a triangle passes the front registers and the queue to the back end;
//   each non-parallel edge then takes a multiply, setup, quotient steps and writeback,
//   and the points are emitted after all edges of the triangle are classified.
// The back end works on one triangle at a time (a parallel edge skips the divide)
//   and emits its points subject to output stall; the next triangle starts after the points.
// Reset (rst, synchronous): queue and pipelines empty, plane = z axis normal.
`default_nettype none
module triangle_plane_slicer import tps_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  // triangle requests
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [CW-1:0] v0_x,
  input  wire logic [CW-1:0] v0_y,
  input  wire logic [CW-1:0] v0_z,
  input  wire logic [CW-1:0] v1_x,
  input  wire logic [CW-1:0] v1_y,
  input  wire logic [CW-1:0] v1_z,
  input  wire logic [CW-1:0] v2_x,
  input  wire logic [CW-1:0] v2_y,
  input  wire logic [CW-1:0] v2_z,
  // point requests
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [CW-1:0]      point_x,
  output logic [CW-1:0]      point_y,
  output logic [CW-1:0]      point_z,
  output logic               last,
  // plane registers
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [CIW-1:0] cfg_index,
  input  wire logic [CW-1:0] cfg_data
);

  plane_t plane;
  tri_t   vert_in;
  job_t   wdata, head;
  logic   full, push, pop, head_valid;

  assign cfg_ready = 1'b1;

  // plane registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      plane.normal[0] <= '0;
      plane.normal[1] <= '0;
      plane.normal[2] <= ONE_FX;
      plane.origin    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NORMAL_X: plane.normal[0] <= cfg_data;
        REG_NORMAL_Y: plane.normal[1] <= cfg_data;
        REG_NORMAL_Z: plane.normal[2] <= cfg_data;
        REG_ORIGIN_X: plane.origin[0] <= cfg_data;
        REG_ORIGIN_Y: plane.origin[1] <= cfg_data;
        REG_ORIGIN_Z: plane.origin[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign vert_in[0][0] = v0_x;
  assign vert_in[0][1] = v0_y;
  assign vert_in[0][2] = v0_z;
  assign vert_in[1][0] = v1_x;
  assign vert_in[1][1] = v1_y;
  assign vert_in[1][2] = v1_z;
  assign vert_in[2][0] = v2_x;
  assign vert_in[2][1] = v2_y;
  assign vert_in[2][2] = v2_z;

  // front: dot products and the quotient-free part of the edge class
  tps_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .vert_in  (vert_in),
    .plane    (plane),
    .full     (full),
    .push     (push),
    .wdata    (wdata)
  );

  // two-deep buffer lets the front keep taking triangles during division
  tps_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wdata      (wdata),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // back: edge points, case table, point emission
  tps_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .last       (last)
  );

endmodule
`default_nettype wire
